### sv/lpec_pkg.sv
`timescale 1ns / 1ps
package lpec_pkg;

	localparam int MAX_ORIGINAL_LINES = 1024;
	localparam int MAX_LINE_LENGTH    = 255;

	localparam int STORE_DEPTH = MAX_ORIGINAL_LINES + 1;
	localparam int COL_W       = 11;
	localparam int LEN_W       = 8;
	localparam int COST_W      = 32;
	localparam int MOVE_W      = 3;

	localparam logic [COST_W-1:0] COST_INF   = '1;
	localparam logic [COST_W-1:0] DELETE_PRICE = COST_W'(10);
	localparam logic [COST_W-1:0] MULTI_PRICE  = COST_W'(15);
	localparam logic [COST_W-1:0] LINE_BASE    = COST_W'(10);

	localparam logic [MOVE_W-1:0] MOVE_ADD   = 3'd0;
	localparam logic [MOVE_W-1:0] MOVE_COPY  = 3'd1;
	localparam logic [MOVE_W-1:0] MOVE_SUB   = 3'd2;
	localparam logic [MOVE_W-1:0] MOVE_DEL   = 3'd3;
	localparam logic [MOVE_W-1:0] MOVE_MULTI = 3'd4;

	// Addition that sticks at the largest cost instead of wrapping.
	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? COST_INF : s[COST_W-1:0];
	endfunction

	// Costs of the fixed row that lies above the first target line.
	function automatic logic [COST_W-1:0] row_zero_cost(input logic [COL_W-1:0] col);
		if (col == '0)
			return '0;
		else if (col == COL_W'(1))
			return DELETE_PRICE;
		else
			return MULTI_PRICE;
	endfunction

endpackage

### sv/lpec_ram.sv
`timescale 1ns / 1ps
module lpec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### sv/line_patch_edit_cost_cell_core.sv
`timescale 1ns / 1ps
// Line patch edit cost cell: cells of the line-diff cost table stream in row by row, one
// transfer per cell, and each yields one result transfer with the cell cost, the chosen move
// and the multi-delete line count. The block takes one cell every clock cycle; each cell
// passes the compute stage into the output register, and the input stalls only while a
// finished result waits at the output and the compute stage behind it is full. That rate is
// set by the left-cost recurrence, which closes in the single compute stage, and by the
// registered read of the previous-row store, whose write from the cell just computed is
// forwarded to a read of the same column issued in the same cycle. The row store needs no
// clearing after reset; every row after the first must be preceded by a complete first row.
module line_patch_edit_cost_cell_core
	import lpec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// column[10:0], lines_equal[11], target_length[19:12], first_row[20], zero fill
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_cost[31:0], move[34:32], delete_count[45:35], zero fill
	output logic [47:0] m_tdata
);

	localparam int ADDR_W = $clog2(STORE_DEPTH);

	logic             in_xfer;
	logic [COL_W-1:0] in_col;

	logic             s1_v_q;
	logic [COL_W-1:0] s1_col_s1;
	logic             s1_equal_s1;
	logic [LEN_W-1:0] s1_len_s1;
	logic             s1_first_s1;
	logic             s1_adv;

	logic              fwd_q;
	logic [COST_W-1:0] fwd_data_q;
	logic [COST_W-1:0] ram_rdata;

	logic [COST_W-1:0] diag_q;
	logic [COST_W-1:0] left_q;
	logic [COST_W-1:0] bd_min_q;
	logic [COL_W-1:0]  bd_col_q;

	logic              out_v_q;
	logic [COST_W-1:0] out_cost_q;
	logic [MOVE_W-1:0] out_move_q;
	logic [COL_W-1:0]  out_count_q;

	logic              in_store;
	logic [LEN_W-1:0]  len_c;
	logic [COST_W-1:0] price;
	logic [COST_W-1:0] above;
	logic [COST_W-1:0] best;
	logic [MOVE_W-1:0] move;
	logic [COL_W-1:0]  count;
	logic [COST_W-1:0] cand_diag;
	logic [COST_W-1:0] cand_del;
	logic [COST_W-1:0] cand_multi;

	assign in_col   = s_tdata[10:0];
	assign s1_adv   = s1_v_q && (!out_v_q || m_tready);
	assign s_tready = !s1_v_q || s1_adv;
	assign in_xfer  = s_tvalid && s_tready;

	lpec_ram #(
		.WIDTH(COST_W),
		.DEPTH(STORE_DEPTH)
	) u_row_store (
		.clk  (clk),
		.we   (s1_adv && in_store),
		.waddr(s1_col_s1[ADDR_W-1:0]),
		.wdata(best),
		.re   (in_xfer),
		.raddr(in_col[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		in_store = 32'(s1_col_s1) <= 32'(MAX_ORIGINAL_LINES);
		len_c    = (32'(s1_len_s1) > 32'(MAX_LINE_LENGTH)) ? LEN_W'(MAX_LINE_LENGTH)
			: s1_len_s1;
		price    = LINE_BASE + COST_W'(len_c);

		if (s1_first_s1)
			above = row_zero_cost(s1_col_s1);
		else if (in_store)
			above = fwd_q ? fwd_data_q : ram_rdata;
		else
			above = COST_INF;

		cand_diag  = sat_add(diag_q, s1_equal_s1 ? '0 : price);
		cand_del   = sat_add(left_q, DELETE_PRICE);
		cand_multi = sat_add(bd_min_q, MULTI_PRICE);

		// Candidates in fixed order; a later one wins only when strictly cheaper.
		best  = sat_add(above, price);
		move  = MOVE_ADD;
		count = '0;
		if (s1_col_s1 != '0) begin
			if (cand_diag < best) begin
				best = cand_diag;
				move = s1_equal_s1 ? MOVE_COPY : MOVE_SUB;
			end
			if (cand_del < best) begin
				best = cand_del;
				move = MOVE_DEL;
			end
			if (bd_min_q != COST_INF && cand_multi < best) begin
				best  = cand_multi;
				move  = MOVE_MULTI;
				count = s1_col_s1 - bd_col_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q   <= 1'b0;
			fwd_q    <= 1'b0;
			out_v_q  <= 1'b0;
			diag_q   <= '0;
			left_q   <= '0;
			bd_min_q <= COST_INF;
			bd_col_q <= '0;
		end else begin
			if (in_xfer)
				s1_v_q <= 1'b1;
			else if (s1_adv)
				s1_v_q <= 1'b0;

			// The store read issued now misses a write of the same column at this edge.
			if (in_xfer)
				fwd_q <= s1_adv && in_store && (s1_col_s1 == in_col);
			else if (s1_adv)
				fwd_q <= 1'b0;

			if (s1_adv)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;

			if (s1_adv) begin
				diag_q <= above;
				left_q <= best;
				if (s1_col_s1 == '0) begin
					bd_min_q <= COST_INF;
				end else if (left_q < bd_min_q) begin
					bd_min_q <= left_q;
					bd_col_q <= s1_col_s1 - COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s1_col_s1   <= in_col;
			s1_equal_s1 <= s_tdata[11];
			s1_len_s1   <= s_tdata[19:12];
			s1_first_s1 <= s_tdata[20];
			fwd_data_q  <= best;
		end
		if (s1_adv) begin
			out_cost_q  <= best;
			out_move_q  <= move;
			out_count_q <= count;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_count_q, out_move_q, out_cost_q};

	a_stall_needs_full_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_v_q && out_v_q)
		else $error("input stalled with a free compute stage");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> s1_v_q)
		else $error("accepted cell missing from compute stage");

	a_forward_has_owner: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> s1_v_q)
		else $error("store forward flagged with empty compute stage");

	a_count_only_multi: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_move_q != MOVE_MULTI |-> out_count_q == '0)
		else $error("delete count set without a multi-delete move");

endmodule
